FILE: rtl/core/nearest_waypoint_search_unit_defines.svh
// assertion macros for the nearest waypoint search unit
// included by the checker; no other dependencies
`ifndef NEAREST_WAYPOINT_SEARCH_UNIT_DEFINES_SVH
`define NEAREST_WAYPOINT_SEARCH_UNIT_DEFINES_SVH

// consequence must hold in the same cycle as the antecedent
`define NWS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the cycle after the antecedent
`define NWS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/nws_pkg.sv
// shared types and constants of the nearest waypoint search unit
// no dependencies
package nws_pkg;

    localparam int POS_W           = 20;
    localparam int YAW_W           = 16;
    localparam int SQ_W            = 40;
    localparam int DIST_W          = 42;
    localparam int NEAREST_INDEX_W = 7;

    // 1000.0 square metres in Q20
    localparam logic [DIST_W-1:0] SEARCH_LIMIT_RESET = 42'd1048576000;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [YAW_W-1:0] yaw;
    } wp_entry_t;

    typedef struct packed {
        logic                    vld;   // sq_dist and yaw are valid this cycle
        logic                    busy;  // some entry still in the pipe
        logic [DIST_W-1:0]       sq_dist;
        logic signed [YAW_W-1:0] yaw;
    } dist_res_t;

endpackage

FILE: rtl/core/nws_dist_pipe.sv
// two-stage squared distance pipe: abs differences, then squares
// depends on nws_pkg
module nws_dist_pipe (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_vld,
    input  nws_pkg::wp_entry_t               entry,
    input  logic signed [nws_pkg::POS_W-1:0] qx,
    input  logic signed [nws_pkg::POS_W-1:0] qy,
    output nws_pkg::dist_res_t               res
);

    localparam int PW = nws_pkg::POS_W;

    logic signed [PW:0]   dx, dy;
    logic [PW-1:0]        adx, ady;
    logic [PW-1:0]        adx_reg, ady_reg;
    logic signed [nws_pkg::YAW_W-1:0] yaw_a_reg, yaw_b_reg;
    logic                 vld_a_reg, vld_b_reg;
    logic [nws_pkg::SQ_W-1:0] sqx_reg, sqy_reg;

    // differences need one extra bit, magnitudes fit back in PW bits
    always_comb begin
        dx  = {entry.x[PW-1], entry.x} - {qx[PW-1], qx};
        dy  = {entry.y[PW-1], entry.y} - {qy[PW-1], qy};
        adx = dx[PW] ? PW'(-dx) : dx[PW-1:0];
        ady = dy[PW] ? PW'(-dy) : dy[PW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end else begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        adx_reg   <= adx;
        ady_reg   <= ady;
        yaw_a_reg <= entry.yaw;
        sqx_reg   <= adx_reg * adx_reg;
        sqy_reg   <= ady_reg * ady_reg;
        yaw_b_reg <= yaw_a_reg;
    end

    always_comb begin
        res.vld     = vld_b_reg;
        res.busy    = vld_a_reg | vld_b_reg;
        res.sq_dist = nws_pkg::DIST_W'(sqx_reg) + nws_pkg::DIST_W'(sqy_reg);
        res.yaw     = yaw_b_reg;
    end

endmodule

FILE: rtl/core/nearest_waypoint_search_unit.sv
// top level of the nearest waypoint search unit: waypoint memory, scan control
// depends on nws_pkg and nws_dist_pipe
//
// Keeps up to MAX_POINTS waypoints (x, y, heading) in one single-port-read
// memory with a registered read port. A clear or an append completes with its
// transfer; an append to a full table is dropped. A query reads the stored
// waypoints one per cycle through the memory read port, forms the exact
// squared distance in a two-stage pipe and keeps the smallest distance below
// search_limit, the earlier waypoint on a tie. A query occupies the block
// through the accept, one read per stored waypoint, the drain of memory output
// register and distance pipe until both are seen empty, and the load of the
// result register. The result register frees the input side:
// the next item is taken while a result still waits on the m_ side. The memory
// is not cleared after reset; only entries below the waypoint count are ever read.
module nearest_waypoint_search_unit #(
    parameter int MAX_POINTS = 128
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // input channel
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic [1:0]                                  s_opcode,
    input  logic signed [nws_pkg::POS_W-1:0]            s_pos_x,
    input  logic signed [nws_pkg::POS_W-1:0]            s_pos_y,
    input  logic signed [nws_pkg::YAW_W-1:0]            s_heading,
    // result channel
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic [nws_pkg::NEAREST_INDEX_W-1:0]         m_nearest_index,
    output logic [nws_pkg::DIST_W-1:0]                  m_nearest_distance,
    output logic signed [nws_pkg::YAW_W-1:0]            m_nearest_yaw,
    output logic                                        m_found,
    // search limit register
    input  logic                                        cfg_wr_en,
    input  logic [nws_pkg::DIST_W-1:0]                  cfg_wr_data
);

    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int IndexOutW = nws_pkg::NEAREST_INDEX_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_POINTS);

    nws_pkg::state_t state_reg, state_next;

    // waypoint memory
    nws_pkg::wp_entry_t mem [MAX_POINTS];
    nws_pkg::wp_entry_t mem_q_reg;
    logic               s1_vld_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   rd_cnt_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;

    // query point and running best
    logic signed [nws_pkg::POS_W-1:0] qx_reg, qy_reg;
    logic [nws_pkg::DIST_W-1:0]       limit_reg;
    logic [nws_pkg::DIST_W-1:0]       best_reg;
    logic [IDX_W-1:0]                 best_idx_reg;
    logic signed [nws_pkg::YAW_W-1:0] best_yaw_reg;
    logic signed [nws_pkg::YAW_W-1:0] yaw0_reg;
    logic                             hit_reg;

    // result register
    logic                                m_valid_reg;
    logic [IndexOutW-1:0]                m_index_reg;
    logic [nws_pkg::DIST_W-1:0]          m_dist_reg;
    logic signed [nws_pkg::YAW_W-1:0]    m_yaw_reg;
    logic                                m_found_reg;

    logic               in_xfer;
    logic               rd_en;
    logic               out_load;
    nws_pkg::opcode_t   op;
    nws_pkg::dist_res_t res;

    assign op      = nws_pkg::opcode_t'(s_opcode);
    assign in_xfer = s_valid && s_ready;

    // control: next state, read issue and result load
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            nws_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && op == nws_pkg::OP_QUERY) begin
                    state_next = nws_pkg::ST_SCAN;
                end
            end
            nws_pkg::ST_SCAN: begin
                rd_en = rd_cnt_reg < count_reg;
                // last entry has left the compare stage
                if (!rd_en && !s1_vld_reg && !res.busy) begin
                    state_next = nws_pkg::ST_RESULT;
                end
            end
            nws_pkg::ST_RESULT: begin
                // wait for the result register to free up
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = nws_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nws_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nws_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // memory write on append, registered read during scan
    always_ff @(posedge aclk) begin
        if (in_xfer && op == nws_pkg::OP_APPEND && count_reg < FULL_CNT) begin
            mem[count_reg[IDX_W-1:0]] <= '{x: s_pos_x, y: s_pos_y, yaw: s_heading};
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_cnt_reg[IDX_W-1:0]];
        end
    end

    // waypoint count, limit register and scan counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            limit_reg   <= nws_pkg::SEARCH_LIMIT_RESET;
            s1_vld_reg  <= 1'b0;
            rd_cnt_reg  <= '0;
            cmp_idx_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (in_xfer) begin
                case (op)
                    nws_pkg::OP_CLEAR: begin
                        count_reg <= '0;
                    end
                    nws_pkg::OP_APPEND: begin
                        if (count_reg < FULL_CNT) begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            s1_vld_reg <= rd_en;
            if (in_xfer && op == nws_pkg::OP_QUERY) begin
                rd_cnt_reg  <= '0;
                cmp_idx_reg <= '0;
            end else begin
                if (rd_en) begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                if (res.vld) begin
                    cmp_idx_reg <= cmp_idx_reg + 1'b1;
                end
            end
        end
    end

    // distance pipe fed from the memory output register
    nws_dist_pipe u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_vld  (s1_vld_reg),
        .entry   (mem_q_reg),
        .qx      (qx_reg),
        .qy      (qy_reg),
        .res     (res)
    );

    // query point capture and running best; strict compare keeps the earlier tie
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (in_xfer && op == nws_pkg::OP_QUERY) begin
            hit_reg <= 1'b0;
        end else if (res.vld && res.sq_dist < best_reg) begin
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && op == nws_pkg::OP_QUERY) begin
            qx_reg       <= s_pos_x;
            qy_reg       <= s_pos_y;
            best_reg     <= limit_reg;
            best_idx_reg <= '0;
        end else if (res.vld) begin
            if (res.sq_dist < best_reg) begin
                best_reg     <= res.sq_dist;
                best_idx_reg <= cmp_idx_reg;
                best_yaw_reg <= res.yaw;
            end
            // heading of entry 0 stands in when nothing beats the limit
            if (cmp_idx_reg == '0) begin
                yaw0_reg <= res.yaw;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_index_reg <= IndexOutW'(best_idx_reg);
            m_dist_reg  <= best_reg;
            m_found_reg <= hit_reg;
            if (hit_reg) begin
                m_yaw_reg <= best_yaw_reg;
            end else if (count_reg != '0) begin
                m_yaw_reg <= yaw0_reg;
            end else begin
                m_yaw_reg <= '0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_nearest_index    = m_index_reg;
    assign m_nearest_distance = m_dist_reg;
    assign m_nearest_yaw      = m_yaw_reg;
    assign m_found            = m_found_reg;

endmodule

FILE: rtl/core/nws_checker.sv
// port-level checks of the nearest waypoint search unit, bound to the top level
// depends on nws_pkg and nearest_waypoint_search_unit_defines.svh
`include "nearest_waypoint_search_unit_defines.svh"

module nws_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic [1:0]                           s_opcode,
    input logic signed [nws_pkg::POS_W-1:0]     s_pos_x,
    input logic signed [nws_pkg::POS_W-1:0]     s_pos_y,
    input logic signed [nws_pkg::YAW_W-1:0]     s_heading,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [nws_pkg::NEAREST_INDEX_W-1:0]  m_nearest_index,
    input logic [nws_pkg::DIST_W-1:0]           m_nearest_distance,
    input logic signed [nws_pkg::YAW_W-1:0]     m_nearest_yaw,
    input logic                                 m_found,
    input logic                                 cfg_wr_en,
    input logic [nws_pkg::DIST_W-1:0]           cfg_wr_data
);

    // shadow of the search limit as seen on the port
    logic [nws_pkg::DIST_W-1:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= nws_pkg::SEARCH_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    `NWS_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready,
        s_valid && $stable(s_opcode) && $stable(s_pos_x) && $stable(s_pos_y)
        && $stable(s_heading), "input changed while waiting")
    `NWS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_nearest_distance) && $stable(m_nearest_index)
        && $stable(m_nearest_yaw) && $stable(m_found), "result changed while stalled")
    `NWS_ASSERT_SAME(a_miss_limit, aclk, aresetn, m_valid && !m_found,
        m_nearest_index == '0 && m_nearest_distance == limit_reg,
        "miss result must carry index 0 and the limit")
    `NWS_ASSERT_SAME(a_hit_below, aclk, aresetn, m_valid && m_found,
        m_nearest_distance < limit_reg, "hit distance not below the limit")
    `NWS_ASSERT_NEXT(a_query_busy, aclk, aresetn,
        s_valid && s_ready && s_opcode == nws_pkg::OP_QUERY, !s_ready,
        "input taken during a scan")

endmodule

bind nearest_waypoint_search_unit nws_checker u_nws_checker (.*);
